FILE: design/rhdc_pkg.sv
// Shared types and constants of the range Hamming-distance counter.
// Used by the controller, the datapath and the top level; depends on nothing.
package rhdc_pkg;

  localparam int DIST_W         = 6;
  localparam int COUNT_W        = 62;
  localparam int OUT_TDATA_W    = 64;
  localparam int VALUE_BITS_DEF = 61;

  typedef struct packed {
    logic fill_rd;
    logic fill_wr;
    logic load;
    logic start_lo;
    logic step;
    logic walk_end;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic fill_done;
    logic empty;
    logic lo_zero;
    logic idx_zero;
    logic out_free;
  } sts_t;

endpackage

FILE: design/rhdc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; holds the binomial table of the counter.
module rhdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/rhdc_ctrl.sv
// Controller state machine of the range Hamming-distance counter.
// Depends on rhdc_pkg for the command and status structs.
module rhdc_ctrl
  import rhdc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic s_valid,
  output logic s_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_FILL_RD  = 4'd0;
  localparam logic [3:0] S_FILL_WR  = 4'd1;
  localparam logic [3:0] S_IDLE     = 4'd2;
  localparam logic [3:0] S_CHECK    = 4'd3;
  localparam logic [3:0] S_WALK_HI  = 4'd4;
  localparam logic [3:0] S_END_HI   = 4'd5;
  localparam logic [3:0] S_START_LO = 4'd6;
  localparam logic [3:0] S_WALK_LO  = 4'd7;
  localparam logic [3:0] S_END_LO   = 4'd8;
  localparam logic [3:0] S_DRAIN    = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign s_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_next  = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd.fill_wr = 1'b1;
        state_next  = sts.fill_done ? S_IDLE : S_FILL_RD;
      end
      S_IDLE: begin
        if (s_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = sts.empty ? S_OUT : S_WALK_HI;
      end
      S_WALK_HI: begin
        cmd.step = 1'b1;
        if (sts.idx_zero) begin
          state_next = S_END_HI;
        end
      end
      S_END_HI: begin
        cmd.walk_end = 1'b1;
        state_next   = sts.lo_zero ? S_DRAIN : S_START_LO;
      end
      S_START_LO: begin
        cmd.start_lo = 1'b1;
        state_next   = S_WALK_LO;
      end
      S_WALK_LO: begin
        cmd.step = 1'b1;
        if (sts.idx_zero) begin
          state_next = S_END_LO;
        end
      end
      S_END_LO: begin
        cmd.walk_end = 1'b1;
        state_next   = S_DRAIN;
      end
      S_DRAIN: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL_RD;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/rhdc_datapath.sv
// Datapath of the range Hamming-distance counter: binomial table, bit walk,
// accumulator and output register. Depends on rhdc_pkg and rhdc_ram.
module rhdc_datapath
  import rhdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [VALUE_BITS-1:0] reference,
  input  logic [DIST_W-1:0]     distance,
  input  logic [VALUE_BITS-1:0] range_low,
  input  logic [VALUE_BITS-1:0] range_high,
  output logic                  m_valid,
  input  logic                  m_ready,
  output logic [COUNT_W-1:0]    match_count,
  output logic                  empty_range
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int ADDR_W = IDX_W + DIST_W;
  localparam int DEPTH = VALUE_BITS << DIST_W;
  localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(VALUE_BITS - 1);
  localparam logic [DIST_W-1:0] LAST_COL = '1;

  logic [VALUE_BITS-1:0] ref_q;
  logic [VALUE_BITS-1:0] lo_q;
  logic [VALUE_BITS-1:0] bound;
  logic [DIST_W-1:0]     want;
  logic [DIST_W-1:0]     diff;
  logic [IDX_W-1:0]      idx;
  logic                  walk_sub;
  logic [COUNT_W-1:0]    acc;
  logic                  pend;
  logic                  pend_one;
  logic                  pend_sub;
  logic                  empty_q;
  logic                  lo_zero_q;
  logic [IDX_W-1:0]      fill_row;
  logic [DIST_W-1:0]     fill_col;
  logic [COUNT_W-1:0]    fill_prev;
  logic                  out_valid;
  logic [COUNT_W-1:0]    out_count;
  logic                  out_empty;

  logic                  rb;
  logic                  bb;
  logic [DIST_W+1:0]     rr;
  logic [ADDR_W-1:0]     raddr;
  logic [COUNT_W-1:0]    rdata;
  logic [COUNT_W-1:0]    fill_val;
  logic [COUNT_W-1:0]    opnd;

  // The needed column is negative when the differences so far plus the reference
  // bit already exceed the distance; then the term is zero and no table read counts.
  assign rb = ref_q[idx];
  assign bb = bound[idx];
  assign rr = {2'b00, want} - {2'b00, diff} - {{(DIST_W + 1){1'b0}}, rb};

  assign raddr = cmd.fill_rd ? {fill_row - IDX_W'(1), fill_col} : {idx, rr[DIST_W-1:0]};

  // Pascal rule: row zero holds a single one, column zero copies the entry above,
  // and every other entry is the sum of the two entries above it.
  always_comb begin
    if (fill_row == '0) begin
      fill_val = COUNT_W'(fill_col == '0);
    end else if (fill_col == '0) begin
      fill_val = rdata;
    end else begin
      fill_val = rdata + fill_prev;
    end
  end

  assign opnd = pend_one ? COUNT_W'(1) : rdata;

  rhdc_ram #(
    .WIDTH(COUNT_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.fill_wr),
    .waddr({fill_row, fill_col}),
    .wdata(fill_val),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_row  <= '0;
      fill_col  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.fill_wr) begin
        fill_col <= fill_col + DIST_W'(1);
        if (fill_col == LAST_COL) begin
          fill_row <= fill_row + IDX_W'(1);
        end
      end
      pend <= (cmd.step && bb && !rr[DIST_W+1]) || (cmd.walk_end && (diff == want));
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      fill_prev <= rdata;
    end
    if (cmd.load) begin
      ref_q     <= reference;
      want      <= distance;
      lo_q      <= range_low;
      bound     <= range_high;
      idx       <= TOP_IDX;
      diff      <= '0;
      walk_sub  <= 1'b0;
      acc       <= '0;
      empty_q   <= (range_low > range_high);
      lo_zero_q <= (range_low == '0);
    end else begin
      if (pend) begin
        acc <= pend_sub ? acc - opnd : acc + opnd;
      end
      if (cmd.start_lo) begin
        bound    <= lo_q - VALUE_BITS'(1);
        idx      <= TOP_IDX;
        diff     <= '0;
        walk_sub <= 1'b1;
      end else if (cmd.step) begin
        diff <= diff + DIST_W'(rb ^ bb);
        if (idx != '0) begin
          idx <= idx - IDX_W'(1);
        end
      end
    end
    pend_one <= cmd.walk_end;
    pend_sub <= walk_sub;
    if (cmd.emit) begin
      out_count <= acc;
      out_empty <= empty_q;
    end
  end

  assign sts.fill_done = (fill_row == TOP_IDX) && (fill_col == LAST_COL);
  assign sts.empty     = empty_q;
  assign sts.lo_zero   = lo_zero_q;
  assign sts.idx_zero  = (idx == '0);
  assign sts.out_free  = !out_valid || m_ready;

  assign m_valid     = out_valid;
  assign match_count = out_count;
  assign empty_range = out_empty;

endmodule

FILE: design/range_hamming_distance_count_unit.sv
// Top level of the range Hamming-distance counter.
// Depends on rhdc_pkg, rhdc_ctrl, rhdc_datapath and rhdc_ram.
//
// One item on the input stream carries a reference value, a distance and an
// inclusive range. One item on the output stream returns how many integers
// in the range differ from the reference in exactly that many bit positions,
// with a flag in tuser when the range is empty (the count is then zero).
// After reset the block fills its binomial table, reading and writing one
// entry at a time, and holds s_axis_tready low until it is done.
// The count walks the upper bound and then the lower bound minus one from
// the top bit down, one bit per cycle through the table read port; a new
// item is accepted only after the last one's result is in the output
// register. A range starting at zero skips the second walk, and an empty
// range skips both walks.
// The result sits in an output register; while the receiver stalls, the
// block still accepts and works on the next item and waits only when that
// item's result is ready and the register is still full.
module range_hamming_distance_count_unit
  import rhdc_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int IN_TDATA_W = ((3 * VALUE_BITS + DIST_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0 up: reference, distance, range_low, range_high, zero fill.
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0 up: match_count, zero fill.
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // Fields from bit 0 up: empty_range.
  output logic                   m_axis_tuser
);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [VALUE_BITS-1:0] reference;
  logic [DIST_W-1:0]     distance;
  logic [VALUE_BITS-1:0] range_low;
  logic [VALUE_BITS-1:0] range_high;
  logic [COUNT_W-1:0]    match_count;

  assign reference  = s_axis_tdata[VALUE_BITS-1:0];
  assign distance   = s_axis_tdata[VALUE_BITS +: DIST_W];
  assign range_low  = s_axis_tdata[VALUE_BITS + DIST_W +: VALUE_BITS];
  assign range_high = s_axis_tdata[2 * VALUE_BITS + DIST_W +: VALUE_BITS];

  rhdc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .s_valid(s_axis_tvalid),
    .s_ready(s_axis_tready),
    .sts    (sts),
    .cmd    (cmd)
  );

  rhdc_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .reference  (reference),
    .distance   (distance),
    .range_low  (range_low),
    .range_high (range_high),
    .m_valid    (m_axis_tvalid),
    .m_ready    (m_axis_tready),
    .match_count(match_count),
    .empty_range(m_axis_tuser)
  );

  assign m_axis_tdata = {{(OUT_TDATA_W - COUNT_W){1'b0}}, match_count};

endmodule

FILE: test/range_hamming_distance_count_unit_tb.sv
// Testbench for range_hamming_distance_count_unit: directed table, then random queries.
// Results are checked against typed values or a Pascal-table prefix counter kept here.
// Depends on rhdc_pkg and the range_hamming_distance_count_unit RTL.
`timescale 1ns / 1ps

module range_hamming_distance_count_unit_tb;
  import rhdc_pkg::*;

  localparam int VB = VALUE_BITS_DEF;
  localparam int IN_W = ((3 * VB + DIST_W + 7) / 8) * 8;
  localparam int TAIL_CYCLES = 2 * VB + 16;
  localparam int STUCK_LIMIT = 4 * 2 * 64 * VB;
  localparam int RANDOM_ITEMS = 400;
  localparam int NROWS = 22;
  localparam logic [VB-1:0] ALL1 = '1;
  localparam logic [VB-1:0] ALT_A = 61'h0AAA_AAAA_AAAA_AAAA;
  localparam logic [VB-1:0] ALT_5 = 61'h1555_5555_5555_5555;
  localparam logic [VB-1:0] TOP_BIT = 61'h1000_0000_0000_0000;

  typedef struct packed {
    logic [VB-1:0]     pattern;
    logic [DIST_W-1:0] distance;
    logic [VB-1:0]     lo;
    logic [VB-1:0]     hi;
  } query_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               empty;
  } result_t;

  typedef struct packed {
    query_t  q;
    logic    typed;
    result_t want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_W-1:0]        s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  longint unsigned pascal [0:63][0:63];
  result_t         pending_counts [$];
  row_t            plan [NROWS];
  int              errors = 0;
  int              stuck = 0;
  logic            calm = 1'b0;

  range_hamming_distance_count_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint unsigned matches_upto(logic [VB-1:0] pattern, int want,
                                                   logic [VB-1:0] bound);
    longint unsigned total;
    int diff;
    int need;
    total = 0;
    diff = 0;
    for (int i = VB - 1; i >= 0; i--) begin
      need = want - diff - int'(pattern[i]);
      if (bound[i] && need >= 0 && need <= i) begin
        total += pascal[i][need];
      end
      if (pattern[i] != bound[i]) begin
        diff++;
      end
    end
    if (diff == want) begin
      total++;
    end
    return total;
  endfunction

  function automatic result_t range_match_count(query_t q);
    result_t r;
    longint unsigned total;
    r = '0;
    if (q.lo > q.hi) begin
      r.empty = 1'b1;
    end else begin
      total = matches_upto(q.pattern, int'(q.distance), q.hi);
      if (q.lo != '0) begin
        total -= matches_upto(q.pattern, int'(q.distance), q.lo - 1'b1);
      end
      r.count = total[COUNT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [VB-1:0] random_value();
    logic [63:0] w;
    logic [VB-1:0] v;
    w = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = VB'($urandom_range(0, 300));
      1: v = ALL1 - VB'($urandom_range(0, 300));
      2: v = (VB'(1) << $urandom_range(0, VB - 1)) | (VB'(1) << $urandom_range(0, VB - 1));
      3: v = w[VB-1:0] >> $urandom_range(0, VB - 1);
      default: v = w[VB-1:0];
    endcase
    return v;
  endfunction

  function automatic query_t random_query();
    query_t q;
    logic [VB-1:0] a;
    logic [VB-1:0] b;
    int near;
    q.pattern = random_value();
    a = random_value();
    b = random_value();
    if (a > b) begin
      q.lo = b;
      q.hi = a;
    end else begin
      q.lo = a;
      q.hi = b;
    end
    case ($urandom_range(0, 9))
      0: begin
        q.lo = q.hi + VB'($urandom_range(1, 1000));
        if (q.lo <= q.hi) begin
          q.lo = ALL1;
          q.hi = '0;
        end
      end
      1: q.lo = '0;
      2: begin
        q.lo = a;
        q.hi = (a > ALL1 - 4096) ? ALL1 : a + VB'($urandom_range(0, 4096));
      end
      3: q.hi = q.lo;
      4: q.hi = ALL1;
      default: ;
    endcase
    near = $countones(q.pattern ^ q.lo) + $urandom_range(0, 4) - 2;
    if (near < 0) begin
      near = 0;
    end
    if ($urandom_range(0, 99) < 8) begin
      q.distance = DIST_W'($urandom_range(VB, 63));
    end else if ($urandom_range(0, 1) == 0) begin
      q.distance = DIST_W'(near > VB ? VB : near);
    end else begin
      q.distance = DIST_W'($urandom_range(0, VB));
    end
    return q;
  endfunction

  task automatic send_query(query_t q, result_t want);
    if (!calm && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_W - 3 * VB - DIST_W){1'b0}}, q.hi, q.lo, q.distance, q.pattern};
    @(posedge clk);
    while (!s_axis_tready) begin
      @(posedge clk);
    end
    pending_counts.push_back(want);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 12);
  end

  always @(posedge clk) begin : check_results
    result_t due;
    result_t got;
    got.count = m_axis_tdata[COUNT_W-1:0];
    got.empty = m_axis_tuser;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_counts.size() == 0) begin
        $display("%0t: unexpected result, count %0d empty %0b", $time, got.count, got.empty);
        errors++;
      end else begin
        due = pending_counts.pop_front();
        if (got.count != due.count) begin
          $display("%0t: match_count mismatch, expected %0d actual %0d",
                   $time, due.count, got.count);
          errors++;
        end
        if (got.empty != due.empty) begin
          $display("%0t: empty_range mismatch, expected %0b actual %0b",
                   $time, due.empty, got.empty);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stuck);
      $display("FAIL");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    query_t q;
    for (int n = 0; n < 64; n++) begin
      for (int r = 0; r < 64; r++) begin
        if (r == 0) begin
          pascal[n][r] = 1;
        end else if (r > n) begin
          pascal[n][r] = 0;
        end else begin
          pascal[n][r] = pascal[n-1][r-1] + pascal[n-1][r];
        end
      end
    end

    plan = '{
      '{'{'0,      6'd0,  '0,          '0},          1'b1, '{62'd1,  1'b0}},
      '{'{ALL1,    6'd61, '0,          ALL1},        1'b1, '{62'd1,  1'b0}},
      '{'{'0,      6'd0,  '0,          ALL1},        1'b1, '{62'd1,  1'b0}},
      '{'{'0,      6'd1,  '0,          ALL1},        1'b1, '{62'd61, 1'b0}},
      '{'{ALL1,    6'd0,  ALL1,        ALL1},        1'b1, '{62'd1,  1'b0}},
      '{'{ALL1,    6'd0,  '0,          ALL1 - 1'b1}, 1'b1, '{62'd0,  1'b0}},
      '{'{'0,      6'd0,  61'd5,       61'd4},       1'b1, '{62'd0,  1'b1}},
      '{'{ALL1,    6'd61, ALL1,        '0},          1'b1, '{62'd0,  1'b1}},
      '{'{ALT_A,   6'd62, '0,          ALL1},        1'b1, '{62'd0,  1'b0}},
      '{'{ALL1,    6'd63, '0,          ALL1},        1'b1, '{62'd0,  1'b0}},
      '{'{'0,      6'd0,  61'd1,       ALL1},        1'b1, '{62'd0,  1'b0}},
      '{'{'0,      6'd61, ALL1,        ALL1},        1'b1, '{62'd1,  1'b0}},
      '{'{'0,      6'd61, '0,          ALL1 - 1'b1}, 1'b1, '{62'd0,  1'b0}},
      '{'{'0,      6'd0,  61'h100,     61'hFF},      1'b1, '{62'd0,  1'b1}},
      '{'{'0,      6'd30, '0,          ALL1},        1'b0, '0},
      '{'{ALL1,    6'd31, 61'd1,       ALL1},        1'b0, '0},
      '{'{ALT_A,   6'd20, 61'h1234_5678_9ABC_DEF, 61'h1FED_CBA9_8765_4321}, 1'b0, '0},
      '{'{ALT_5,   6'd3,  ALT_5 ^ 61'd7, ALT_5 ^ 61'd7}, 1'b0, '0},
      '{'{'0,      6'd1,  '0,          TOP_BIT},     1'b0, '0},
      '{'{'0,      6'd2,  TOP_BIT - 1'b1, TOP_BIT + 1'b1}, 1'b0, '0},
      '{'{ALL1,    6'd60, 61'd1,       61'd255},     1'b0, '0},
      '{'{61'h1F0F_0F0F_0F0F_0F0F, 6'd45, '0, TOP_BIT}, 1'b0, '0}
    };

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < NROWS; i++) begin
      send_query(plan[i].q, plan[i].typed ? plan[i].want : range_match_count(plan[i].q));
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 150 && n < 240);
      q = random_query();
      send_query(q, range_match_count(q));
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending_counts.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
